@@ hdl/slcf_pkg.sv @@
// shared constants and types for the slash command line framer
// no dependencies; imported by slash_command_line_framer_unit
package slcf_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;
    localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_CHAR    = 8'h0A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } framer_state_t;

endpackage

@@ hdl/slash_command_line_framer_unit.sv @@
// slash command line framer: collects "/command" lines and streams them out
// depends on slcf_pkg (constants, state type)
//
// input channel: rx_valid / rx_stall / rx_byte, one received character per request.
// output channel: cmd_valid / cmd_stall with cmd_byte, last and truncated.
// bytes before a '/' are dropped; a '/' (re)starts a command; CR or LF ends it
// and the stored bytes are sent in order, last marked on the final one and
// truncated set there when bytes past LINE_DEPTH were dropped. a CR or LF that
// directly follows a terminator is ignored, so CRLF ends a line once.
// an ordinary byte is taken and, while a command is being collected, written
// to the line memory. at a terminator the input stalls while the line is
// read back: each stored byte passes a memory read (ST_READ), then a load of
// the output register (ST_SEND), one byte at a time through the single read
// port of the line memory, and rx_stall stays high until the final byte is
// loaded.
// a stalled output holds its request; the read-out waits until the output
// register is free. bytes that do not end a line are still taken while an
// earlier result waits at the output.
// reset (rst_n low) empties the line and drops any output request; the line
// memory itself is not cleared.
module slash_command_line_framer_unit
    import slcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output logic [BYTE_W-1:0] cmd_byte,
    output logic              last,
    output logic              truncated
);

    framer_state_t state_reg, state_next;

    logic              collecting_reg;
    logic              skip_eol_reg;
    logic              overflowed_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic              cmd_valid_reg;
    logic [BYTE_W-1:0] cmd_byte_reg;
    logic              last_reg;
    logic              truncated_reg;

    logic [BYTE_W-1:0] line_store [LINE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              rx_take;
    logic              is_eol;
    logic              is_slash;
    logic              store_full;
    logic              mem_we;
    logic              mem_re;
    logic              out_free;
    logic              load_out;
    logic              emit_last;
    logic              start_emit;

    assign is_eol     = (rx_byte == CR_CHAR) || (rx_byte == LF_CHAR);
    assign is_slash   = (rx_byte == SLASH_CHAR);
    assign store_full = (count_reg >= CNT_W'(LINE_DEPTH));
    assign out_free   = !cmd_valid_reg || !cmd_stall;
    assign emit_last  = ((emit_idx_reg + CNT_W'(1)) == count_reg);

    // output / control decode
    always_comb
    begin
        rx_stall   = (state_reg != ST_IDLE);
        rx_take    = rx_valid && (state_reg == ST_IDLE);
        mem_we     = rx_take && !is_eol && !is_slash && collecting_reg && !store_full;
        mem_re     = (state_reg == ST_READ);
        load_out   = (state_reg == ST_SEND) && out_free;
        start_emit = rx_take && is_eol && !skip_eol_reg && collecting_reg
                     && (count_reg != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_emit)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (load_out)
                    state_next = emit_last ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // line memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_store[count_reg[ADDR_W-1:0]] <= rx_byte;
        if (mem_re)
            rd_data_reg <= line_store[emit_idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            collecting_reg <= 1'b0;
            skip_eol_reg   <= 1'b0;
            overflowed_reg <= 1'b0;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
            cmd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (rx_take)
            begin
                if (is_eol)
                begin
                    if (skip_eol_reg)
                        skip_eol_reg <= 1'b0;
                    else if (collecting_reg)
                    begin
                        collecting_reg <= 1'b0;
                        skip_eol_reg   <= 1'b1;
                        emit_idx_reg   <= '0;
                        // empty command: nothing to send
                        if (count_reg == '0)
                            overflowed_reg <= 1'b0;
                    end
                end
                else
                begin
                    skip_eol_reg <= 1'b0;
                    if (is_slash)
                    begin
                        collecting_reg <= 1'b1;
                        count_reg      <= '0;
                        overflowed_reg <= 1'b0;
                    end
                    else if (collecting_reg)
                    begin
                        if (!store_full)
                            count_reg <= count_reg + CNT_W'(1);
                        else
                            overflowed_reg <= 1'b1;
                    end
                end
            end

            if (load_out)
            begin
                cmd_valid_reg <= 1'b1;
                emit_idx_reg  <= emit_idx_reg + CNT_W'(1);
                if (emit_last)
                begin
                    count_reg      <= '0;
                    overflowed_reg <= 1'b0;
                end
            end
            else if (!cmd_stall)
                cmd_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            cmd_byte_reg  <= rd_data_reg;
            last_reg      <= emit_last;
            truncated_reg <= emit_last && overflowed_reg;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd_byte  = cmd_byte_reg;
    assign last      = last_reg;
    assign truncated = truncated_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LINE_DEPTH))
        else $error("line count beyond depth");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (emit_idx_reg < count_reg))
        else $error("read-out index past stored bytes");

    a_last_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && emit_last) |=> (state_reg == ST_IDLE) && (count_reg == '0)
                                     && cmd_valid && last)
        else $error("line not released after final byte");

    a_trunc_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (!truncated || last))
        else $error("truncated flag on a non-final byte");

endmodule

@@ tb/slcf_tb_pkg.sv @@
// command line tracker for the slash command line framer testbench
// depends on slcf_pkg (depth, character codes); used by tb_slash_command_line_framer_unit
package slcf_tb_pkg;

    import slcf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] cmd_byte;
        logic              last;
        logic              truncated;
    } cmd_char_t;

    class cmd_line_tracker;

        logic              collecting;
        logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
        logic [CNT_W-1:0]  fill;
        logic              skip_eol;
        logic              dropped;
        cmd_char_t         pending_chars [$];
        int                failures;

        function new();
            collecting = 1'b0;
            fill       = '0;
            skip_eol   = 1'b0;
            dropped    = 1'b0;
            failures   = 0;
        endfunction

        // a request taken by the framer: update the line and queue any output it causes
        function void note_request(logic [BYTE_W-1:0] rx);
            cmd_char_t c;
            if (rx == CR_CHAR || rx == LF_CHAR)
            begin
                if (skip_eol)
                begin
                    skip_eol = 1'b0;
                    return;
                end
                if (!collecting)
                    return;
                for (int i = 0; i < fill; i++)
                begin
                    c.cmd_byte  = line_mem[ADDR_W'(i)];
                    c.last      = (i + 1 == fill);
                    c.truncated = (i + 1 == fill) && dropped;
                    pending_chars.push_back(c);
                end
                collecting = 1'b0;
                fill       = '0;
                dropped    = 1'b0;
                skip_eol   = 1'b1;
                return;
            end
            skip_eol = 1'b0;
            if (rx == SLASH_CHAR)
            begin
                collecting = 1'b1;
                fill       = '0;
                dropped    = 1'b0;
            end
            else if (collecting)
            begin
                if (fill < LINE_DEPTH)
                begin
                    line_mem[fill[ADDR_W-1:0]] = rx;
                    fill                       = fill + 1'b1;
                end
                else
                begin
                    dropped = 1'b1;
                end
            end
        endfunction

        function void check_result(logic [BYTE_W-1:0] data, logic lst, logic trunc);
            cmd_char_t exp_c;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected output: cmd_byte %02h last %0b truncated %0b",
                       data, lst, trunc);
                failures++;
                return;
            end
            exp_c = pending_chars.pop_front();
            if (data !== exp_c.cmd_byte)
            begin
                $error("cmd_byte: expected %02h, actual %02h", exp_c.cmd_byte, data);
                failures++;
            end
            if (lst !== exp_c.last)
            begin
                $error("last: expected %0b, actual %0b", exp_c.last, lst);
                failures++;
            end
            if (trunc !== exp_c.truncated)
            begin
                $error("truncated: expected %0b, actual %0b", exp_c.truncated, trunc);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction

    endclass

endpackage

@@ tb/tb_slash_command_line_framer_unit.sv @@
// top level testbench for slash_command_line_framer_unit
// depends on slcf_pkg and slcf_tb_pkg (command line tracker)
module tb_slash_command_line_framer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import slcf_pkg::*;
    import slcf_tb_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int TARGET_SENT    = 260;
    localparam int DRAIN_CYCLES   = 2 * LINE_DEPTH + 16;
    localparam int CYCLE_LIMIT    = 400000;

    logic              clk;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              cmd_valid;
    logic              cmd_stall;
    logic [BYTE_W-1:0] cmd_byte;
    logic              last;
    logic              truncated;

    cmd_line_tracker tracker;
    int              requests_sent;
    logic            rx_burst;
    logic            cmd_burst;

    slash_command_line_framer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_byte  (cmd_byte),
        .last      (last),
        .truncated (truncated)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // offer one request after a random gap and hold it until taken
    task automatic send_request(input logic [BYTE_W-1:0] value);
        int gap;
        gap = rx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (rx_stall);
        tracker.note_request(value);
        requests_sent++;
    endtask

    // '/' + body + terminator; term: 0 CR, 1 LF, 2 CR LF, 3 LF CR, 4 LF LF
    task automatic send_command(input int len, input int term, input logic restart);
        logic [BYTE_W-1:0] b;
        int                cut;
        cut = restart ? $urandom_range(0, len) : -1;
        send_request(SLASH_CHAR);
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
                send_request(SLASH_CHAR);
            do
                b = BYTE_W'($urandom_range(0, 255));
            while (b == SLASH_CHAR || b == CR_CHAR || b == LF_CHAR);
            send_request(b);
        end
        case (term)
            0: send_request(CR_CHAR);
            1: send_request(LF_CHAR);
            2:
            begin
                send_request(CR_CHAR);
                send_request(LF_CHAR);
            end
            3:
            begin
                send_request(LF_CHAR);
                send_request(CR_CHAR);
            end
            default:
            begin
                send_request(LF_CHAR);
                send_request(LF_CHAR);
            end
        endcase
    endtask

    task automatic directed_requests();
        logic [BYTE_W-1:0] seq [] = '{
            // idle bytes and an idle terminator
            8'h00, 8'hFF, 8'h78, LF_CHAR,
            // empty command, then a pair and a lone terminator
            SLASH_CHAR, CR_CHAR, LF_CHAR, LF_CHAR,
            // extreme bytes with crlf
            SLASH_CHAR, 8'h00, 8'hFF, 8'h7F, CR_CHAR, LF_CHAR,
            // restart mid command, lf cr
            SLASH_CHAR, 8'h61, 8'h62, SLASH_CHAR, 8'h63, LF_CHAR, CR_CHAR,
            // single byte, lf lf
            SLASH_CHAR, 8'h71, LF_CHAR, LF_CHAR
        };
        foreach (seq[i])
            send_request(seq[i]);
    endtask

    task automatic random_requests();
        int kind;
        int len;
        // full store and overflow first
        send_command(LINE_DEPTH, 0, 1'b0);
        send_command(LINE_DEPTH + 2, 2, 1'b0);
        while (requests_sent < TARGET_SENT)
        begin
            rx_burst = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 9);
            if (kind == 0)
                send_request(BYTE_W'($urandom_range(0, 255)));
            else if (kind == 1)
            begin
                // broken sequence, heavy on control characters
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 5))
                        0: send_request(SLASH_CHAR);
                        1: send_request(CR_CHAR);
                        2: send_request(LF_CHAR);
                        default: send_request(BYTE_W'($urandom_range(0, 255)));
                    endcase
                end
            end
            else
            begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(LINE_DEPTH - 4, LINE_DEPTH + 6)
                                                   : $urandom_range(0, 10);
                send_command(len, $urandom_range(0, 4), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic take_results();
        int hold;
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                cmd_burst = ~cmd_burst;
            hold = cmd_burst ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                cmd_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            cmd_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(cmd_valid && !cmd_stall));
            tracker.check_result(cmd_byte, last, truncated);
        end
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        rx_valid  <= 1'b0;
        rx_byte   <= '0;
        cmd_stall <= 1'b0;
        rx_burst  = 1'b0;
        cmd_burst = 1'b0;
        requests_sent = 0;
        tracker   = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        fork
            take_results();
        join_none
        directed_requests();
        random_requests();
        rx_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
